>>> design/dvf_pkg.sv
package dvf_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_INV_MASS   = 3'd0;
  localparam logic [2:0] CFG_DRY_LIMIT  = 3'd1;
  localparam logic [2:0] CFG_START_COEF = 3'd2;
  localparam logic [2:0] CFG_VISC_COEF  = 3'd3;
  localparam logic [2:0] CFG_TIME_STEP  = 3'd4;
  localparam logic [2:0] CFG_INV_STEP   = 3'd5;
  localparam logic [2:0] CFG_USE_INPUT  = 3'd6;
  localparam logic [2:0] CFG_INIT_POS   = 3'd7;

  // input action codes
  localparam logic ACT_STEP    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // step sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_THR,
    ST_LACC,
    ST_LVEL,
    ST_LPOS,
    ST_VISC,
    ST_SACC,
    ST_SVEL,
    ST_SPOS,
    ST_STOPA,
    ST_STOPB,
    ST_STOPC,
    ST_STOPD,
    ST_OUT
  } seq_state_t;

endpackage

>>> design/dvf_if.sv
interface dvf_in_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic signed [WORD_BITS-1:0] external_force;
  logic        [WORD_BITS-2:0] limit_in;

  modport source (output valid, action, external_force, limit_in, input ready);
  modport sink   (input valid, action, external_force, limit_in, output ready);
endinterface

interface dvf_out_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] position;
  logic signed [WORD_BITS-1:0] velocity;
  logic signed [WORD_BITS-1:0] acceleration;
  logic signed [WORD_BITS-1:0] friction_force;
  logic                        moving;

  modport source (output valid, position, velocity, acceleration, friction_force, moving,
                  input ready);
  modport sink   (input valid, position, velocity, acceleration, friction_force, moving,
                  output ready);
endinterface

>>> design/dvf_mul.sv
module dvf_mul #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [WORD_BITS-1:0] a,
  input  logic signed [WORD_BITS-1:0] b,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] res
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int CW = $clog2(W);
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]  ma_r, ma_nxt;
  logic [W-1:0]  hi_r, hi_nxt;
  logic [W-1:0]  lo_r, lo_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          fin_r, fin_nxt;
  logic          done_r, done_nxt;
  logic [W-1:0]  res_r, res_nxt;

  logic [W:0]       sum;
  logic [2*W-1:0]   prod;
  logic [2*W-F-1:0] m_full;
  logic [2*W-F-1:0] m_lim;
  logic [W-1:0]     mval;
  logic [W-1:0]     mag_a;
  logic [W-1:0]     mag_b;

  // one shift-add step per cycle, lsb of the multiplier first
  always_comb begin
    mag_a   = a[W-1] ? (~a + 1'b1) : a;
    mag_b   = b[W-1] ? (~b + 1'b1) : b;
    sum     = {1'b0, hi_r} + (lo_r[0] ? {1'b0, ma_r} : {(W+1){1'b0}});
    prod    = {hi_r, lo_r};
    m_full  = prod[2*W-1:F];
    m_lim   = {{(W-F){1'b0}}, neg_r, {(W-1){~neg_r}}};
    mval    = m_full[W-1:0];

    ma_nxt   = ma_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    res_nxt  = res_r;

    if (start) begin
      ma_nxt   = mag_a;
      lo_nxt   = mag_b;
      hi_nxt   = '0;
      neg_nxt  = a[W-1] ^ b[W-1];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = sum[W:1];
      lo_nxt  = {sum[0], lo_r[W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W-1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end

    // scale, saturate and restore the sign
    if (fin_r) begin
      done_nxt = 1'b1;
      if (m_full > m_lim) begin
        res_nxt = neg_r ? SMIN : SMAX;
      end else begin
        res_nxt = neg_r ? (~mval + 1'b1) : mval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    ma_r  <= ma_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;
endmodule

>>> design/dvf_div.sv
module dvf_div #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic        [WORD_BITS-1:0] num,
  input  logic        [WORD_BITS:0]   den,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] quo
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int CW = $clog2(F + 1);

  logic [W:0]    r_r, r_nxt;
  logic [W:0]    d_r, d_nxt;
  logic [F:0]    q_r, q_nxt;
  logic          dz_r, dz_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [W+1:0] t;
  logic [W+1:0] diff;
  logic         ge;

  // restoring division, one quotient bit per cycle, integer bit first
  always_comb begin
    t    = (cnt_r == '0) ? {1'b0, r_r} : {r_r, 1'b0};
    diff = t - {1'b0, d_r};
    ge   = t >= {1'b0, d_r};

    r_nxt    = r_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    dz_nxt   = dz_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      r_nxt    = {1'b0, num};
      d_nxt    = den;
      dz_nxt   = (den == '0);
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      r_nxt   = ge ? diff[W:0] : t[W:0];
      q_nxt   = {q_r[F-1:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(F)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    r_r  <= r_nxt;
    d_r  <= d_nxt;
    q_r  <= q_nxt;
    dz_r <= dz_nxt;
  end

  assign done = done_r;
  assign quo  = dz_r ? '0 : {{(W-F-1){1'b0}}, q_r};
endmodule

>>> design/dry_viscous_friction_mass_step.sv
// Mass under dry and viscous friction with sticking, one time step per item.
// Input channel in_chan carries action (0 step, 1 restart), external_force and
// limit_in; each accepted item gives exactly one result on out_chan: position,
// velocity, acceleration, friction_force (all signed fixed point) and moving.
// Registers are written through cfg_we / cfg_idx / cfg_wdata, by the user only while
// the block is idle (not enforced by the block); writes take effect for the next item.
// The block handles one item at a time: in_chan.ready is high only when idle.
// All products go through a single shift-add multiplier; the stopping ratio
// uses a restoring divider. A restart uses no product, a tick that stays
// stuck one, a breakaway or sliding tick 4 products, and a tick that stops
// 6 products plus the division.
// The result is held in the state registers and shown with out_chan.valid
// until taken; while the receiver stalls no new item is accepted.
// Synchronous reset puts the body at rest, stuck, at position zero, and
// loads the register defaults.
module dry_viscous_friction_mass_step_core #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dvf_in_if.sink               in_chan,
  dvf_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_idx,
  input  logic [WORD_BITS-1:0] cfg_wdata
);
  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam logic [W-1:0]   SMAX      = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   SMIN      = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-2:0]   ONE_FX    = (W-1)'(1) << F;
  localparam logic [W-2:0]   DT_RST    = ONE_FX / (W-1)'(100);
  localparam logic [W-2:0]   INV_DT_RST = (W-1)'(100) << F;

  // saturating add and negate, magnitude and halving helpers
  function automatic logic [W-1:0] sat_add(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) begin
      return s[W] ? SMIN : SMAX;
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_neg(input logic [W-1:0] x);
    return (x == SMIN) ? SMAX : (~x + 1'b1);
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [W-1:0] half(input logic [W-1:0] x);
    logic [W-1:0] t;
    t = x + {{(W-1){1'b0}}, x[W-1]};
    return {t[W-1], t[W-1:1]};
  endfunction

  // configuration registers
  logic [W-2:0] imass_r, dry_r, sfc_r, visc_r, dt_r, idt_r;
  logic         uil_r;
  logic [W-1:0] init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imass_r <= ONE_FX;
      dry_r   <= '0;
      sfc_r   <= '0;
      visc_r  <= '0;
      dt_r    <= DT_RST;
      idt_r   <= INV_DT_RST;
      uil_r   <= 1'b0;
      init_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        dvf_pkg::CFG_INV_MASS:   imass_r <= cfg_wdata[W-2:0];
        dvf_pkg::CFG_DRY_LIMIT:  dry_r   <= cfg_wdata[W-2:0];
        dvf_pkg::CFG_START_COEF: sfc_r   <= cfg_wdata[W-2:0];
        dvf_pkg::CFG_VISC_COEF:  visc_r  <= cfg_wdata[W-2:0];
        dvf_pkg::CFG_TIME_STEP:  dt_r    <= cfg_wdata[W-2:0];
        dvf_pkg::CFG_INV_STEP:   idt_r   <= cfg_wdata[W-2:0];
        dvf_pkg::CFG_USE_INPUT:  uil_r   <= cfg_wdata[0];
        dvf_pkg::CFG_INIT_POS:   init_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer and body state
  dvf_pkg::seq_state_t state_r, state_nxt;
  logic [W-1:0] pos_r, pos_nxt;
  logic [W-1:0] vel_r, vel_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] frc_r, frc_nxt;
  logic         sld_r, sld_nxt;
  logic         act_r, act_nxt;
  logic [W-1:0] fx_r, fx_nxt;
  logic [W-2:0] lim_r, lim_nxt;
  logic [W-1:0] vnew_r, vnew_nxt;
  logic [W-1:0] tmp_r, tmp_nxt;

  logic         mul_start;
  logic [W-1:0] mul_a, mul_b;
  logic         mul_done;
  logic [W-1:0] mul_res;
  logic         div_start;
  logic [W-1:0] div_num;
  logic [W:0]   div_den;
  logic         div_done;
  logic [W-1:0] div_q;

  logic [W-1:0] lim_s, thr, f1, f2, v, vsum;
  logic         vo_pos, vo_neg, v_pos, v_neg;

  dvf_mul #(.WORD_BITS(W), .FRAC_BITS(F)) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  dvf_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q)
  );

  always_comb begin
    lim_s  = {1'b0, lim_r};
    vo_pos = !vel_r[W-1] && (vel_r != '0);
    vo_neg = vel_r[W-1];
    thr    = sat_add(lim_s, mul_res);
    f1     = sat_add(fx_r, vo_pos ? (~lim_s + 1'b1) : (vo_neg ? lim_s : '0));
    f2     = sat_add(f1, sat_neg(mul_res));
    v      = sat_add(vel_r, mul_res);
    v_pos  = !v[W-1] && (v != '0);
    v_neg  = v[W-1];
    vsum   = sat_add(v, vel_r);

    state_nxt = state_r;
    pos_nxt   = pos_r;
    vel_nxt   = vel_r;
    acc_nxt   = acc_r;
    frc_nxt   = frc_r;
    sld_nxt   = sld_r;
    act_nxt   = act_r;
    fx_nxt    = fx_r;
    lim_nxt   = lim_r;
    vnew_nxt  = vnew_r;
    tmp_nxt   = tmp_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = mag(vel_r);
    div_den   = {1'b0, mag(vel_r)} + {1'b0, mag(vnew_r)};

    in_chan.ready  = (state_r == dvf_pkg::ST_IDLE);
    out_chan.valid = (state_r == dvf_pkg::ST_OUT);

    case (state_r)
      dvf_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          act_nxt   = in_chan.action;
          fx_nxt    = in_chan.external_force;
          lim_nxt   = uil_r ? in_chan.limit_in : dry_r;
          state_nxt = dvf_pkg::ST_DECODE;
        end
      end
      dvf_pkg::ST_DECODE: begin
        if (act_r == dvf_pkg::ACT_RESTART) begin
          pos_nxt   = init_r;
          vel_nxt   = '0;
          acc_nxt   = '0;
          frc_nxt   = '0;
          sld_nxt   = 1'b0;
          state_nxt = dvf_pkg::ST_OUT;
        end else if (!sld_r) begin
          mul_start = 1'b1;
          mul_a     = lim_s;
          mul_b     = {1'b0, sfc_r};
          state_nxt = dvf_pkg::ST_THR;
        end else begin
          mul_start = 1'b1;
          mul_a     = vel_r;
          mul_b     = {1'b0, visc_r};
          state_nxt = dvf_pkg::ST_VISC;
        end
      end
      // stuck: compare against breakaway threshold
      dvf_pkg::ST_THR: begin
        if (mul_done) begin
          if (mag(fx_r) <= thr) begin
            frc_nxt   = sat_neg(fx_r);
            state_nxt = dvf_pkg::ST_OUT;
          end else begin
            frc_nxt   = sat_add(fx_r, fx_r[W-1] ? lim_s : (~lim_s + 1'b1));
            mul_start = 1'b1;
            mul_a     = frc_nxt;
            mul_b     = {1'b0, imass_r};
            state_nxt = dvf_pkg::ST_LACC;
          end
        end
      end
      dvf_pkg::ST_LACC: begin
        if (mul_done) begin
          acc_nxt   = mul_res;
          mul_start = 1'b1;
          mul_a     = mul_res;
          mul_b     = {1'b0, dt_r};
          state_nxt = dvf_pkg::ST_LVEL;
        end
      end
      dvf_pkg::ST_LVEL: begin
        if (mul_done) begin
          vnew_nxt  = mul_res;
          mul_start = 1'b1;
          mul_a     = mul_res;
          mul_b     = {1'b0, dt_r};
          state_nxt = dvf_pkg::ST_LPOS;
        end
      end
      dvf_pkg::ST_LPOS: begin
        if (mul_done) begin
          pos_nxt   = sat_add(pos_r, half(mul_res));
          vel_nxt   = vnew_r;
          sld_nxt   = 1'b1;
          state_nxt = dvf_pkg::ST_OUT;
        end
      end
      // sliding: net force from dry and viscous terms
      dvf_pkg::ST_VISC: begin
        if (mul_done) begin
          frc_nxt   = f2;
          mul_start = 1'b1;
          mul_a     = f2;
          mul_b     = {1'b0, imass_r};
          state_nxt = dvf_pkg::ST_SACC;
        end
      end
      dvf_pkg::ST_SACC: begin
        if (mul_done) begin
          acc_nxt   = mul_res;
          mul_start = 1'b1;
          mul_a     = mul_res;
          mul_b     = {1'b0, dt_r};
          state_nxt = dvf_pkg::ST_SVEL;
        end
      end
      dvf_pkg::ST_SVEL: begin
        if (mul_done) begin
          vnew_nxt  = v;
          mul_start = 1'b1;
          if ((vo_pos && v_pos) || (vo_neg && v_neg)) begin
            mul_a     = vsum;
            mul_b     = {1'b0, dt_r};
            state_nxt = dvf_pkg::ST_SPOS;
          end else begin
            mul_a     = v;
            mul_b     = {1'b0, idt_r};
            state_nxt = dvf_pkg::ST_STOPA;
          end
        end
      end
      dvf_pkg::ST_SPOS: begin
        if (mul_done) begin
          pos_nxt   = sat_add(pos_r, half(mul_res));
          vel_nxt   = vnew_r;
          state_nxt = dvf_pkg::ST_OUT;
        end
      end
      // stopping: deceleration, then distance to the zero crossing
      dvf_pkg::ST_STOPA: begin
        if (mul_done) begin
          acc_nxt   = sat_neg(mul_res);
          mul_start = 1'b1;
          mul_a     = vel_r;
          mul_b     = {1'b0, dt_r};
          state_nxt = dvf_pkg::ST_STOPB;
        end
      end
      dvf_pkg::ST_STOPB: begin
        if (mul_done) begin
          tmp_nxt   = mul_res;
          div_start = 1'b1;
          state_nxt = dvf_pkg::ST_STOPC;
        end
      end
      dvf_pkg::ST_STOPC: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = tmp_r;
          mul_b     = div_q;
          state_nxt = dvf_pkg::ST_STOPD;
        end
      end
      dvf_pkg::ST_STOPD: begin
        if (mul_done) begin
          pos_nxt   = sat_add(pos_r, half(mul_res));
          vel_nxt   = '0;
          sld_nxt   = 1'b0;
          state_nxt = dvf_pkg::ST_OUT;
        end
      end
      dvf_pkg::ST_OUT: begin
        if (out_chan.ready) begin
          state_nxt = dvf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dvf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dvf_pkg::ST_IDLE;
      pos_r   <= '0;
      vel_r   <= '0;
      acc_r   <= '0;
      frc_r   <= '0;
      sld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      vel_r   <= vel_nxt;
      acc_r   <= acc_nxt;
      frc_r   <= frc_nxt;
      sld_r   <= sld_nxt;
    end
    act_r  <= act_nxt;
    fx_r   <= fx_nxt;
    lim_r  <= lim_nxt;
    vnew_r <= vnew_nxt;
    tmp_r  <= tmp_nxt;
  end

  // result payload straight from the body state
  assign out_chan.position       = pos_r;
  assign out_chan.velocity       = vel_r;
  assign out_chan.acceleration   = acc_r;
  assign out_chan.friction_force = frc_r;
  assign out_chan.moving         = sld_r;

  // never accepting while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("input accepted while result pending");

  // after a result transfer the block is ready again
  a_ready_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready) |=> in_chan.ready)
    else $error("not ready after result transfer");

  // a restart is decoded, then shown as a body at rest in the result state
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.action == dvf_pkg::ACT_RESTART) |->
      ##2 (out_chan.valid && !out_chan.moving && out_chan.velocity == '0))
    else $error("restart result wrong");

  // a stuck body reports zero velocity
  a_stuck_still: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.moving) |-> (out_chan.velocity == '0))
    else $error("stuck body with nonzero velocity");
endmodule
